FILE: rtl/core/csi_pkg.sv
// Shared types, constants and helpers for the column standardizer.
`timescale 1ns / 1ps
package csi_pkg;

  localparam int MAX_ROWS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 23;
  localparam int SUMSQ_W  = 38;
  localparam int NUM_W    = 2 * SUM_W;
  localparam int VAL_W    = 32;
  localparam int SCALE_W  = 31;
  localparam int QUOT_W   = 64;

  localparam int MEAN_CAP_E   = 40;
  localparam int VAR_CAP_E    = 62;
  localparam int SAMPLE_CAP_E = 34;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_DATA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_EN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DATA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPUTE_EN   = 3'd4;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_FEW  = 2'd1,
    ERR_ZERO = 2'd2
  } csi_err_t;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic [SCALE_W-1:0] SCALE_MAX = 31'h7fff_ffff;

  typedef struct packed {
    logic load;
    logic mean_start;
    logic mean_latch;
    logic var_start;
    logic sqrt_start;
    logic scale_latch;
    logic rd;
    logic calc;
    logic sdiv_start;
    logic out_load;
    logic col_done;
  } csi_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic need_div;
    logic last_row;
    logic out_free;
  } csi_stat_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 64'(VAL_MAX)) r = VAL_MAX;
    else if (v < 64'(VAL_MIN)) r = VAL_MIN;
    else r = v[VAL_W-1:0];
    return r;
  endfunction

  function automatic logic [QUOT_W-1:0] cap_q(input logic [QUOT_W-1:0] q, input logic ovf,
                                             input int e);
    logic [QUOT_W-1:0] c;
    c = 64'd1 << e;
    return (ovf || q >= c) ? c : q;
  endfunction

endpackage

FILE: rtl/core/csi_if.sv
// Valid/ready channel interfaces for samples and results.
`timescale 1ns / 1ps
interface csi_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] sample;
  logic sample_missing;
  logic signed [31:0] given_center;
  logic [30:0] given_scale;
  logic last_in_column;
  modport source(output valid, sample, sample_missing, given_center, given_scale,
                 last_in_column, input ready);
  modport sink(input valid, sample, sample_missing, given_center, given_scale,
               last_in_column, output ready);
endinterface

interface csi_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] value;
  logic value_missing;
  logic signed [31:0] column_center;
  logic [30:0] column_scale;
  logic [1:0] stats_error;
  logic last_of_column;
  modport source(output valid, value, value_missing, column_center, column_scale,
                 stats_error, last_of_column, input ready);
  modport sink(input valid, value, value_missing, column_center, column_scale,
               stats_error, last_of_column, output ready);
endinterface

FILE: rtl/core/csi_div.sv
// Bit-serial restoring divider with a quotient overflow flag.
`timescale 1ns / 1ps
module csi_div import csi_pkg::*; #(
  parameter int DW = NUM_W + 2 * FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DW-1:0]       dividend,
  input  logic [SCALE_W-1:0]  divisor,
  output logic                done,
  output logic [QUOT_W-1:0]   quot,
  output logic                ovf
);
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]      dvd;
  logic [SCALE_W-1:0] den;
  logic [SCALE_W-1:0] rem;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [SCALE_W:0]   r2;
  logic [SCALE_W:0]   r_sub;
  logic               ge;

  assign r2    = {rem, dvd[DW-1]};
  assign ge    = r2 >= {1'b0, den};
  assign r_sub = r2 - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      den  <= divisor;
      rem  <= '0;
      quot <= '0;
      ovf  <= 1'b0;
    end else if (busy) begin
      dvd  <= {dvd[DW-2:0], 1'b0};
      rem  <= ge ? r_sub[SCALE_W-1:0] : r2[SCALE_W-1:0];
      quot <= {quot[QUOT_W-2:0], ge};
      ovf  <= ovf | quot[QUOT_W-1];
    end
  end
endmodule

FILE: rtl/core/csi_sqrt.sv
// Iterative integer square root, two radicand bits examined per step.
`timescale 1ns / 1ps
module csi_sqrt import csi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [QUOT_W-1:0] radicand,
  output logic              done,
  output logic [31:0]       root
);
  logic [QUOT_W-1:0] v;
  logic [QUOT_W-1:0] res;
  logic [QUOT_W-1:0] bt;
  logic [QUOT_W-1:0] trial;
  logic [5:0]        cnt;
  logic              busy;

  assign trial = res + bt;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v   <= radicand;
      res <= '0;
      bt  <= 64'd1 << 62;
    end else if (busy) begin
      if (v >= trial) begin
        v   <= v - trial;
        res <= (res >> 1) + bt;
      end else begin
        res <= res >> 1;
      end
      bt <= bt >> 2;
    end
  end
endmodule

FILE: rtl/core/csi_ctrl.sv
// Sequencer: load the column, form the statistics, emit one result per row.
`timescale 1ns / 1ps
module csi_ctrl import csi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  input  csi_stat_t st,
  output csi_cmd_t  cmd
);
  typedef enum logic [10:0] {
    S_LOAD   = 11'b000_0000_0001,
    S_MEAN   = 11'b000_0000_0010,
    S_MEAN_W = 11'b000_0000_0100,
    S_VAR    = 11'b000_0000_1000,
    S_VAR_W  = 11'b000_0001_0000,
    S_SQRT_W = 11'b000_0010_0000,
    S_RD     = 11'b000_0100_0000,
    S_CALC   = 11'b000_1000_0000,
    S_SDIV_W = 11'b001_0000_0000,
    S_OUT    = 11'b010_0000_0000,
    S_SPARE  = 11'b100_0000_0000
  } csi_state_t;

  csi_state_t state, state_next;

  assign in_ready = (state == S_LOAD);

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_next = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd.mean_start = 1'b1;
        state_next = S_MEAN_W;
      end
      S_MEAN_W: begin
        if (st.div_done) begin
          cmd.mean_latch = 1'b1;
          state_next = S_VAR;
        end
      end
      S_VAR: begin
        cmd.var_start = 1'b1;
        state_next = S_VAR_W;
      end
      S_VAR_W: begin
        if (st.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_next = S_SQRT_W;
        end
      end
      S_SQRT_W: begin
        if (st.sqrt_done) begin
          cmd.scale_latch = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        if (st.need_div) begin
          cmd.sdiv_start = 1'b1;
          state_next = S_SDIV_W;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SDIV_W: begin
        if (st.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.last_row) begin
            cmd.col_done = 1'b1;
            state_next = S_LOAD;
          end else begin
            state_next = S_RD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end
endmodule

FILE: rtl/core/csi_dp.sv
// Datapath: row buffer, accumulators, statistics units and result register.
`timescale 1ns / 1ps
module csi_dp import csi_pkg::*; #(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  csi_cmd_t                   cmd,
  output csi_stat_t                  st,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       sample_missing,
  input  logic signed [VAL_W-1:0]    given_center,
  input  logic [SCALE_W-1:0]         given_scale,
  input  logic                       last_in_column,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [VAL_W-1:0]    value,
  output logic                       value_missing,
  output logic signed [VAL_W-1:0]    column_center,
  output logic [SCALE_W-1:0]         column_scale,
  output logic [1:0]                 stats_error,
  output logic                       last_of_column
);
  localparam int AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = $clog2(MAX_ROWS + 1);
  localparam int DW  = NUM_W + 2 * FRAC_BITS;
  localparam int DSW = 34 + FRAC_BITS;

  // configuration
  logic ce, cfd, se, sfd, ie;

  always_ff @(posedge clk) begin
    if (rst) begin
      ce  <= 1'b0;
      cfd <= 1'b1;
      se  <= 1'b0;
      sfd <= 1'b1;
      ie  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_EN:   ce  <= cfg_data[0];
        CFG_CENTER_DATA: cfd <= cfg_data[0];
        CFG_SCALE_EN:    se  <= cfg_data[0];
        CFG_SCALE_DATA:  sfd <= cfg_data[0];
        CFG_IMPUTE_EN:   ie  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // row buffer and accumulators
  logic [SAMPLE_W:0]          mem [MAX_ROWS];
  logic [SAMPLE_W:0]          rd_data;
  logic [CW-1:0]              row_count;
  logic [CW-1:0]              present;
  logic signed [SUM_W-1:0]    sum;
  logic [SUMSQ_W-1:0]         sumsq;
  logic [AW-1:0]              idx;
  logic                       full;
  logic signed [2*SAMPLE_W-1:0] sq;
  logic signed [VAL_W-1:0]    gcenter;
  logic [SCALE_W-1:0]         gscale;

  assign full = (row_count == CW'(MAX_ROWS));
  assign sq   = sample * sample;

  always_ff @(posedge clk) begin
    if (cmd.load && !full) mem[row_count[AW-1:0]] <= {sample_missing, sample};
    if (cmd.rd) rd_data <= mem[idx];
    if (cmd.load && last_in_column) begin
      gcenter <= given_center;
      gscale  <= given_scale;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.col_done) begin
      row_count <= '0;
      present   <= '0;
      sum       <= '0;
      sumsq     <= '0;
      idx       <= '0;
    end else begin
      if (cmd.load && !full) begin
        row_count <= row_count + 1'b1;
        if (!sample_missing) begin
          present <= present + 1'b1;
          sum     <= sum + SUM_W'(sample);
          sumsq   <= sumsq + SUMSQ_W'($unsigned(sq));
        end
      end
      if (cmd.out_load) idx <= idx + 1'b1;
    end
  end

  // statistics operands
  logic [NUM_W-1:0]        prod_a;
  logic [NUM_W-1:0]        prod_b;
  logic [2*CW-1:0]         prod_c;
  logic signed [NUM_W-1:0] sum_ext;
  logic [NUM_W-1:0]        num;
  logic [SUM_W-1:0]        sum_mag;

  assign sum_ext = NUM_W'(sum);
  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign num     = (prod_a > prod_b) ? prod_a - prod_b : '0;

  always_ff @(posedge clk) begin
    prod_a <= NUM_W'(present) * NUM_W'(sumsq);
    prod_b <= sum_ext * sum_ext;
    prod_c <= (2*CW)'(present) * (2*CW)'(present - 1'b1);
  end

  // shared divider and square root
  logic [DW-1:0]      div_dvd;
  logic [SCALE_W-1:0] div_den;
  logic               div_done;
  logic [QUOT_W-1:0]  quot;
  logic               ovf;
  logic               sqrt_done;
  logic [31:0]        root;
  logic [QUOT_W-1:0]  var_q;
  logic signed [DSW-1:0] d_comb;
  logic [DSW-1:0]     d_mag;
  logic signed [VAL_W-1:0] mean;
  logic [SCALE_W-1:0] scale;
  logic signed [VAL_W-1:0] center;

  assign center = cfd ? mean : gcenter;
  assign d_comb = (DSW'($signed(rd_data[SAMPLE_W-1:0])) <<< FRAC_BITS)
                  - (ce ? DSW'(center) : DSW'(0));
  assign d_mag  = d_comb[DSW-1] ? DSW'(-d_comb) : DSW'(d_comb);

  always_comb begin
    div_dvd = DW'(d_mag) << (FRAC_BITS + 1);
    div_den = scale;
    if (cmd.mean_start) begin
      div_dvd = DW'(sum_mag) << (FRAC_BITS + 1);
      div_den = SCALE_W'(present);
    end else if (cmd.var_start) begin
      div_dvd = DW'(num) << (2 * FRAC_BITS);
      div_den = SCALE_W'(prod_c);
    end
  end

  csi_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mean_start | cmd.var_start | cmd.sdiv_start),
    .dividend (div_dvd),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (quot),
    .ovf      (ovf)
  );

  assign var_q = cap_q(quot, ovf, VAR_CAP_E);

  csi_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (var_q),
    .done     (sqrt_done),
    .root     (root)
  );

  // mean: round half away from zero, then saturate; scale: given, capped root, or zero
  logic [QUOT_W-1:0] mean_q;
  logic [QUOT_W-1:0] mean_r;

  assign mean_q = cap_q(quot, ovf, MEAN_CAP_E);
  assign mean_r = (mean_q + 64'd1) >> 1;

  always_ff @(posedge clk) begin
    if (cmd.mean_latch) begin
      if (present == '0) mean <= '0;
      else mean <= sat32(sum[SUM_W-1] ? -$signed(mean_r) : $signed(mean_r));
    end
    if (cmd.scale_latch) begin
      if (!sfd) scale <= gscale;
      else if (present > CW'(1)) scale <= (root > 32'(SCALE_MAX)) ? SCALE_MAX
                                                                 : root[SCALE_W-1:0];
      else scale <= '0;
    end
  end

  // error code
  logic     mean_used;
  logic     sd_used;
  csi_err_t err;

  assign mean_used = (ce && cfd) || (ie && !ce);
  assign sd_used   = se && sfd;

  always_comb begin
    if ((mean_used && present == '0) || (sd_used && present <= CW'(1))) err = ERR_FEW;
    else if (se && scale == '0) err = ERR_ZERO;
    else err = ERR_NONE;
  end

  // per-row value
  logic signed [DSW-1:0]   d_reg;
  logic                    miss_reg;
  logic [QUOT_W-1:0]       smp_q;
  logic [QUOT_W-1:0]       smp_r;
  logic signed [VAL_W-1:0] val_div;
  logic signed [VAL_W-1:0] value_n;
  logic                    vm_n;

  assign smp_q   = cap_q(quot, ovf, SAMPLE_CAP_E);
  assign smp_r   = (smp_q + 64'd1) >> 1;
  assign val_div = sat32(d_reg[DSW-1] ? -$signed(smp_r) : $signed(smp_r));

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      d_reg    <= d_comb;
      miss_reg <= rd_data[SAMPLE_W];
    end
  end

  always_comb begin
    vm_n = 1'b0;
    if (miss_reg) begin
      value_n = (ie && !ce) ? mean : '0;
      vm_n    = !ie;
    end else if (se) begin
      if (scale != '0) value_n = val_div;
      else if (d_reg > 0) value_n = VAL_MAX;
      else if (d_reg < 0) value_n = VAL_MIN;
      else value_n = '0;
    end else begin
      value_n = sat32(64'(d_reg));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value          <= value_n;
      value_missing  <= vm_n;
      column_center  <= center;
      column_scale   <= scale;
      stats_error    <= err;
      last_of_column <= st.last_row;
    end
  end

  assign st.div_done  = div_done;
  assign st.sqrt_done = sqrt_done;
  assign st.need_div  = !rd_data[SAMPLE_W] && se && (scale != '0);
  assign st.last_row  = (idx == AW'(row_count - 1'b1));
  assign st.out_free  = !out_valid || out_ready;
endmodule

FILE: rtl/core/column_standardize_impute.sv
// Top level of the column standardizer with mean imputation.
//
//   port     dir  kind        payload
//   in_ch    in   valid/ready sample, sample_missing, given_center, given_scale, last_in_column
//   out_ch   out  valid/ready value, value_missing, column_center, column_scale,
//                             stats_error, last_of_column
//   cfg_*    in   write only  cfg_index selects one of five 1-bit registers
//
// Requests are loaded while the sequencer waits for a column. After the last request
// of a column the shared serial divider, DW = 46+2*FRAC_BITS (78 by default) bits wide,
// runs twice (mean, variance), then the square root runs. Each row then passes through
// the read, calculate and output states, plus a divider run when scaled by a nonzero scale.
// Reset is synchronous and clears control state. A stalled output holds the
// sequencer; no new column is accepted until the last result is loaded.
`timescale 1ns / 1ps
module column_standardize_impute import csi_pkg::*; #(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  csi_in_if.sink                in_ch,
  csi_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  csi_cmd_t  cmd;
  csi_stat_t st;

  csi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_in_column),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  csi_dp #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample         (in_ch.sample),
    .sample_missing (in_ch.sample_missing),
    .given_center   (in_ch.given_center),
    .given_scale    (in_ch.given_scale),
    .last_in_column (in_ch.last_in_column),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .value          (out_ch.value),
    .value_missing  (out_ch.value_missing),
    .column_center  (out_ch.column_center),
    .column_scale   (out_ch.column_scale),
    .stats_error    (out_ch.stats_error),
    .last_of_column (out_ch.last_of_column)
  );

`ifndef SYNTH
  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.value_missing |-> out_ch.value == '0)
    else $error("missing result carries a nonzero value");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.stats_error != 2'd3)
    else $error("undefined stats error code");

  a_no_load_during_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !in_ch.ready)
    else $error("input taken while results are emitted");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_ch.valid)
    else $error("result valid right after reset");
`endif
endmodule

FILE: tb/column_standardize_impute_tb.sv
// Self-checking testbench for the column standardizer with mean imputation.
`timescale 1ns / 1ps
module column_standardize_impute_tb import csi_pkg::*; ();

  typedef struct {
    logic signed [31:0] value;
    logic               missing;
    logic signed [31:0] center;
    logic [30:0]        scale;
    csi_err_t           err;
    logic               last;
  } zresult_t;

  // cfg word bit i is register index i
  typedef struct {
    logic [4:0]         cfg;
    logic signed [15:0] x;
    logic               miss;
    logic signed [31:0] gc;
    logic [30:0]        gs;
    logic               last;
    logic               typed;
    logic signed [31:0] ev;
    logic               em;
    logic signed [31:0] ec;
    logic [30:0]        es;
    csi_err_t           ee;
  } stim_row_t;

  localparam logic [4:0] CFG_RESET = 5'b01010;
  localparam logic [4:0] CFG_ALL   = 5'b11111;
  localparam logic [4:0] CFG_NONE  = 5'b00000;
  localparam logic [4:0] CFG_GIVEN = 5'b00101;
  localparam logic [4:0] CFG_IMP   = 5'b11000;
  localparam logic [4:0] CFG_SCL   = 5'b01111;
  localparam logic [CFG_IDX_W-1:0] REG_IDX [5] =
    '{CFG_CENTER_EN, CFG_CENTER_DATA, CFG_SCALE_EN, CFG_SCALE_DATA, CFG_IMPUTE_EN};
  localparam int NDIR = 22;
  localparam int NPHASE = 8;
  localparam logic [4:0] PHASE_CFG [NPHASE] =
    '{CFG_RESET, CFG_ALL, CFG_NONE, CFG_GIVEN, CFG_SCL, CFG_IMP, 5'b10011, 5'b00111};

  stim_row_t stim_tab [NDIR] = '{
    '{CFG_RESET, 16'sd32767, 1'b0, 0, 0, 1'b1, 1'b1, 32'sh7fff0000, 1'b0, 32'sh7fff0000, 0,
      ERR_NONE},
    '{CFG_RESET, -16'sd32768, 1'b0, 0, 0, 1'b1, 1'b1, 32'sh80000000, 1'b0, 32'sh80000000, 0,
      ERR_NONE},
    '{CFG_RESET, 16'sd0, 1'b1, 0, 0, 1'b1, 1'b1, 0, 1'b1, 0, 0, ERR_NONE},
    '{CFG_ALL, 16'sd9, 1'b1, 0, 0, 1'b1, 1'b1, 0, 1'b0, 0, 0, ERR_FEW},
    '{CFG_ALL, 16'sd5, 1'b0, 0, 0, 1'b0, 1'b0, 0, 1'b0, 0, 0, ERR_NONE},
    '{CFG_ALL, 16'sd5, 1'b0, 0, 0, 1'b1, 1'b0, 0, 1'b0, 0, 0, ERR_NONE},
    '{CFG_ALL, 16'sd100, 1'b0, 0, 0, 1'b0, 1'b0, 0, 1'b0, 0, 0, ERR_NONE},
    '{CFG_ALL, -16'sd7, 1'b1, 0, 0, 1'b0, 1'b0, 0, 1'b0, 0, 0, ERR_NONE},
    '{CFG_ALL, -16'sd300, 1'b0, 0, 0, 1'b1, 1'b0, 0, 1'b0, 0, 0, ERR_NONE},
    '{CFG_GIVEN, 16'sd100, 1'b0, 0, 0, 1'b0, 1'b0, 0, 1'b0, 0, 0, ERR_NONE},
    '{CFG_GIVEN, -16'sd100, 1'b0, 0, 0, 1'b0, 1'b0, 0, 1'b0, 0, 0, ERR_NONE},
    '{CFG_GIVEN, 16'sd0, 1'b1, 0, 0, 1'b0, 1'b0, 0, 1'b0, 0, 0, ERR_NONE},
    '{CFG_GIVEN, 16'sd0, 1'b0, 0, 0, 1'b1, 1'b0, 0, 1'b0, 0, 0, ERR_NONE},
    '{CFG_GIVEN, 16'sd32767, 1'b0, 32'sh80000000, 31'h7fffffff, 1'b1, 1'b0, 0, 1'b0, 0, 0,
      ERR_NONE},
    '{CFG_GIVEN, -16'sd32768, 1'b0, 32'sh7fffffff, 31'd1, 1'b1, 1'b0, 0, 1'b0, 0, 0,
      ERR_NONE},
    '{CFG_IMP, 16'sd3, 1'b0, 0, 0, 1'b0, 1'b0, 0, 1'b0, 0, 0, ERR_NONE},
    '{CFG_IMP, 16'sd0, 1'b1, 0, 0, 1'b0, 1'b0, 0, 1'b0, 0, 0, ERR_NONE},
    '{CFG_IMP, 16'sd8, 1'b0, 0, 0, 1'b1, 1'b0, 0, 1'b0, 0, 0, ERR_NONE},
    '{CFG_NONE, 16'sd1, 1'b1, 0, 0, 1'b1, 1'b0, 0, 1'b0, 0, 0, ERR_NONE},
    '{CFG_NONE, -16'sd1, 1'b0, -32'sd1, 31'h40000000, 1'b1, 1'b0, 0, 1'b0, 0, 0, ERR_NONE},
    '{CFG_SCL, 16'sd32767, 1'b0, 0, 0, 1'b0, 1'b0, 0, 1'b0, 0, 0, ERR_NONE},
    '{CFG_SCL, -16'sd32768, 1'b0, 0, 0, 1'b1, 1'b0, 0, 1'b0, 0, 0, ERR_NONE}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  csi_in_if  in_ch ();
  csi_out_if out_ch ();

  column_standardize_impute uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [4:0]  cur_cfg;
  logic [16:0] col_rows [64];
  int          col_len, col_present;
  longint      col_sum;
  longint      col_sumsq;

  zresult_t expected_q [$];
  int  fail_count, item_count, result_count, column_count, clipped_count;
  bit  quiet, hold_go, hold_done;

  function automatic longint unsigned scaled_div(longint unsigned mag, longint unsigned den,
                                                 int sh, longint unsigned cap);
    longint unsigned q, r;
    q = mag / den;
    r = mag % den;
    if (q >= cap) return cap;
    for (int i = 0; i < sh; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
      if (q >= cap) return cap;
    end
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Buffer one sample; on the column end, queue the standardized column.
  task automatic standardize_sample(logic signed [15:0] x, logic miss,
                                    logic signed [31:0] gc, logic [30:0] gs, logic last);
    longint unsigned n, mag, num, s2, q;
    longint mean, center, scale, d, v;
    csi_err_t err;
    bit mean_used, sd_used;
    zresult_t r;
    if (col_len < 64) begin
      col_rows[col_len] = {miss, x};
      col_len++;
      if (!miss) begin
        col_present++;
        col_sum += longint'(x);
        col_sumsq += longint'(x) * longint'(x);
      end
    end else begin
      clipped_count++;
    end
    if (!last) return;
    n = col_present;
    mean = 0;
    if (n > 0) begin
      mag = (col_sum < 0) ? -col_sum : col_sum;
      mag = (scaled_div(mag, n, 17, 64'd1 << 40) + 1) >> 1;
      mean = clamp32(col_sum < 0 ? -longint'(mag) : longint'(mag));
    end
    center = cur_cfg[1] ? mean : longint'(gc);
    scale = 0;
    if (cur_cfg[3]) begin
      if (n > 1) begin
        s2 = col_sum * col_sum;
        num = n * col_sumsq;
        num = (num > s2) ? num - s2 : 0;
        q = int_sqrt(scaled_div(num, n * (n - 1), 32, 64'd1 << 62));
        scale = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
      end
    end else begin
      scale = longint'(gs);
    end
    mean_used = (cur_cfg[0] && cur_cfg[1]) || (cur_cfg[4] && !cur_cfg[0]);
    sd_used = cur_cfg[2] && cur_cfg[3];
    if ((mean_used && n == 0) || (sd_used && n <= 1)) err = ERR_FEW;
    else if (cur_cfg[2] && scale == 0) err = ERR_ZERO;
    else err = ERR_NONE;
    for (int i = 0; i < col_len; i++) begin
      v = 0;
      r.missing = 1'b0;
      if (col_rows[i][16]) begin
        if (cur_cfg[4]) v = cur_cfg[0] ? 0 : mean;
        else r.missing = 1'b1;
      end else begin
        d = longint'($signed(col_rows[i][15:0])) * 65536;
        if (cur_cfg[0]) d = d - center;
        if (cur_cfg[2]) begin
          if (scale == 0) begin
            v = (d > 0) ? 64'sd2147483647 : (d < 0 ? -64'sd2147483648 : 0);
          end else begin
            mag = (d < 0) ? -d : d;
            mag = (scaled_div(mag, scale, 17, 64'd1 << 34) + 1) >> 1;
            v = clamp32(d < 0 ? -longint'(mag) : longint'(mag));
          end
        end else begin
          v = clamp32(d);
        end
      end
      r.value = v[31:0];
      r.center = center[31:0];
      r.scale = scale[30:0];
      r.err = err;
      r.last = (i == col_len - 1);
      expected_q.push_back(r);
    end
    col_len = 0;
    col_present = 0;
    col_sum = 0;
    col_sumsq = 0;
    column_count++;
  endtask

  // Offer one request, with an occasional idle burst first, and predict on acceptance.
  task automatic send_sample(logic signed [15:0] x, logic miss, logic signed [31:0] gc,
                             logic [30:0] gs, logic last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= x;
    in_ch.sample_missing <= miss;
    in_ch.given_center <= gc;
    in_ch.given_scale <= gs;
    in_ch.last_in_column <= last;
    do @(posedge clk); while (!in_ch.ready);
    item_count++;
    standardize_sample(x, miss, gc, gs, last);
  endtask

  // Drain, let the sequencer settle, then write all five registers.
  task automatic load_config(logic [4:0] bits);
    in_ch.valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (20) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_IDX[i];
      cfg_data <= bits[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_cfg = bits;
  endtask

  task automatic send_random_column(int len);
    logic signed [15:0] base, x;
    logic [30:0] gs;
    int miss_pct, spread;
    base = $urandom;
    spread = 1 << $urandom_range(0, 15);
    miss_pct = ($urandom_range(0, 4) == 0) ? 60 : 15;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0: x = 16'sh7fff;
        1: x = 16'sh8000;
        2: x = $urandom;
        default: x = base + $signed(16'($urandom_range(0, spread)));
      endcase
      case ($urandom_range(0, 9))
        0: gs = 0;
        1, 2, 3: gs = $urandom_range(1, 1 << 18);
        default: gs = $urandom;
      endcase
      send_sample(x, $urandom_range(0, 99) < miss_pct, $urandom, gs, i == len - 1);
    end
  endtask

  // Result sink: random stall bursts, one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_go && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    zresult_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      result_count++;
      if (expected_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result value=%h last=%b", $time, out_ch.value,
                 out_ch.last_of_column);
      end else begin
        e = expected_q.pop_front();
        if (out_ch.value !== e.value || out_ch.value_missing !== e.missing ||
            out_ch.column_center !== e.center || out_ch.column_scale !== e.scale ||
            out_ch.stats_error !== e.err || out_ch.last_of_column !== e.last) begin
          fail_count++;
          $display("%0t: mismatch expected val=%h miss=%b ctr=%h scl=%h err=%0d last=%b",
                   $time, e.value, e.missing, e.center, e.scale, e.err, e.last);
          $display("%0t:          actual   val=%h miss=%b ctr=%h scl=%h err=%0d last=%b",
                   $time, out_ch.value, out_ch.value_missing, out_ch.column_center,
                   out_ch.column_scale, out_ch.stats_error, out_ch.last_of_column);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    int target;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_CENTER_EN;
    cfg_data <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.sample <= 0;
    in_ch.sample_missing <= 1'b0;
    in_ch.given_center <= 0;
    in_ch.given_scale <= 0;
    in_ch.last_in_column <= 1'b0;
    cur_cfg = CFG_RESET;
    col_len = 0;
    col_present = 0;
    col_sum = 0;
    col_sumsq = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NDIR; i++) begin
      if (stim_tab[i].cfg != cur_cfg || i == 0) load_config(stim_tab[i].cfg);
      send_sample(stim_tab[i].x, stim_tab[i].miss, stim_tab[i].gc, stim_tab[i].gs,
                  stim_tab[i].last);
      // single-row columns whose outcome is obvious: hold the typed value instead
      if (stim_tab[i].typed) begin
        void'(expected_q.pop_back());
        expected_q.push_back('{stim_tab[i].ev, stim_tab[i].em, stim_tab[i].ec,
                               stim_tab[i].es, stim_tab[i].ee, 1'b1});
      end
    end

    target = item_count;
    for (int p = 0; p < NPHASE + 2; p++) begin
      load_config(p < NPHASE ? PHASE_CFG[p] : 5'($urandom));
      quiet = (p == NPHASE + 1);
      target += 32;
      if (p == 1) begin
        // send one column, then hold off the sink while the next one is offered
        send_random_column(30);
        hold_go = 1'b1;
        send_random_column(8);
      end
      while (item_count < target) begin
        if ($urandom_range(0, 19) == 0) send_random_column($urandom_range(64, 70));
        else send_random_column($urandom_range(1, 12));
      end
    end
    in_ch.valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (200) @(posedge clk);

    $display("Covered %0d samples in %0d columns (%0d past the row limit), %0d results.",
             item_count, column_count, clipped_count, result_count);
    $display("Mismatches: %0d; long sink hold-off done: %0d.", fail_count, hold_done);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
